/* src/cfb_pkg.sv */
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared constants, input/output widths, AES S-box and xtime helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

  localparam int KEY_SLOTS   = 15;
  localparam int BLOCK_BYTES = 16;
  localparam int BLK_W       = 8 * BLOCK_BYTES;
  localparam int SLOT_W      = 4;
  localparam int POS_W       = $clog2(BLOCK_BYTES);

  localparam logic [3:0] RC_MIN   = 4'd10;
  localparam logic [3:0] RC_MAX   = 4'(KEY_SLOTS - 1);
  localparam logic [3:0] RC_RESET = 4'd10;

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 136;

  typedef enum logic [1:0] {
    OP_LOAD_KEY = 2'd0,
    OP_LOAD_IV  = 2'd1,
    OP_DEC_BLK  = 2'd2,
    OP_DEC_BYTE = 2'd3
  } op_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

`default_nettype wire

/* src/aes_cfb128_decrypt.sv */
// ----------------------------------------------------------------------------
// aes_cfb128_decrypt
// AES CFB-128 decryption with byte position, round keys in an on-chip RAM.
// ----------------------------------------------------------------------------
// Key and IV loads take effect when accepted. A byte or block request steps
//   in ST_BYTE, passing ST_KEY and ST_RUN first when the keystream must be
//   refilled (position 0); nr = 10..14. A new request is taken only in ST_IDLE;
//   a refill runs rounds 0..nr, one AES round per cycle from the key RAM.
// Reset (rst_n low, synchronous): feedback, keystream, position cleared,
//   round_count = 10; the key RAM is not cleared and must be loaded.
`default_nettype none

module aes_cfb128_decrypt (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // config: round_count
  input  wire logic                            cfg_we,
  input  wire logic [3:0]                      cfg_wdata,
  // request: op[1:0], key_slot[5:2], word_high[69:6], word_low[133:70],
  //          cipher_byte[141:134], zero fill
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [cfb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result: plain_high[63:0], plain_low[127:64], plain_byte[135:128]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [cfb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_KEY,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t state_r, state_nxt;

  // request fields
  logic [1:0]  in_op;
  logic [3:0]  in_slot;
  logic [63:0] in_hi, in_lo;
  logic [7:0]  in_cb;
  logic        in_acc;

  assign in_op   = in_tdata[1:0];
  assign in_slot = in_tdata[5:2];
  assign in_hi   = in_tdata[69:6];
  assign in_lo   = in_tdata[133:70];
  assign in_cb   = in_tdata[141:134];
  assign in_acc  = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // state
  logic [3:0]                  rc_r;
  logic [cfb_pkg::BLK_W-1:0]   fb_r, ks_r, st_r, blk_r, plain_r;
  logic [cfb_pkg::POS_W-1:0]   pos_r, idx_r;
  logic [7:0]                  cb_r;
  logic                        is_blk_r, refilled_r;
  logic [3:0]                  rnd_r;
  logic                        out_valid_r;
  logic [cfb_pkg::OUT_TDATA_W-1:0] out_data_r;

  // saturated round count
  logic [3:0] nr;
  always_comb begin
    if (rc_r < cfb_pkg::RC_MIN) begin
      nr = cfb_pkg::RC_MIN;
    end else if (rc_r > cfb_pkg::RC_MAX) begin
      nr = cfb_pkg::RC_MAX;
    end else begin
      nr = rc_r;
    end
  end

  // round key RAM: {bytes 8..15, bytes 0..7} per slot
  logic                      key_we;
  logic [cfb_pkg::SLOT_W-1:0] key_raddr;
  logic [cfb_pkg::BLK_W-1:0] key_rdata;

  assign key_we = in_acc && (in_op == cfb_pkg::OP_LOAD_KEY) &&
                  (in_slot < 4'(cfb_pkg::KEY_SLOTS));
  // read one round ahead; slot 0 is fetched in ST_KEY
  assign key_raddr = (state_r == ST_RUN && rnd_r != nr) ? rnd_r + 4'd1 : '0;

  cfb_ram #(
    .WIDTH (cfb_pkg::BLK_W),
    .DEPTH (cfb_pkg::KEY_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_slot),
    .wdata ({in_hi, in_lo}),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // AES round datapath
  logic                      rnd_first, rnd_last;
  logic [cfb_pkg::BLK_W-1:0] rnd_in, rnd_out;

  assign rnd_first = (rnd_r == 4'd0);
  assign rnd_last  = (rnd_r == nr);
  assign rnd_in    = rnd_first ? fb_r : st_r;

  cfb_round u_round (
    .st_i    (rnd_in),
    .rk_i    (key_rdata),
    .first_i (rnd_first),
    .last_i  (rnd_last),
    .st_o    (rnd_out)
  );

  // byte step: xor with keystream byte, overwrite it with the cipher byte
  logic [7:0]                c_byte, p_byte;
  logic [cfb_pkg::BLK_W-1:0] ks_step, plain_step;
  logic                      need_refill, step_last, out_free, out_set;

  always_comb begin
    c_byte     = is_blk_r ? blk_r[{idx_r, 3'b000} +: 8] : cb_r;
    p_byte     = ks_r[{pos_r, 3'b000} +: 8] ^ c_byte;
    ks_step    = ks_r;
    ks_step[{pos_r, 3'b000} +: 8] = c_byte;
    plain_step = plain_r;
    plain_step[{idx_r, 3'b000} +: 8] = p_byte;
  end

  assign need_refill = (pos_r == '0) && !refilled_r;
  assign step_last   = !is_blk_r || (idx_r == '1);
  assign out_free    = !out_valid_r || out_tready;
  // new result loaded into the output register
  assign out_set     = ((state_r == ST_BYTE) && !need_refill && step_last && out_free) ||
                       ((state_r == ST_HOLD) && out_free);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == cfb_pkg::OP_DEC_BLK || in_op == cfb_pkg::OP_DEC_BYTE)) begin
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (need_refill) begin
          state_nxt = ST_KEY;
        end else if (step_last) begin
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_KEY:  state_nxt = ST_RUN;
      ST_RUN:  state_nxt = rnd_last ? ST_BYTE : ST_RUN;
      ST_HOLD: state_nxt = out_free ? ST_IDLE : ST_HOLD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rc_r        <= cfb_pkg::RC_RESET;
      fb_r        <= '0;
      ks_r        <= '0;
      pos_r       <= '0;
      refilled_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rnd_r       <= '0;
      idx_r       <= '0;
      is_blk_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        rc_r <= cfg_wdata;
      end
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            blk_r    <= {in_hi, in_lo};
            cb_r     <= in_cb;
            idx_r    <= '0;
            is_blk_r <= (in_op == cfb_pkg::OP_DEC_BLK);
            plain_r  <= '0;
            if (in_op == cfb_pkg::OP_LOAD_IV) begin
              fb_r       <= {in_hi, in_lo};
              pos_r      <= '0;
              refilled_r <= 1'b0;
            end
          end
        end
        ST_BYTE: begin
          if (!need_refill) begin
            ks_r       <= ks_step;
            plain_r    <= plain_step;
            refilled_r <= 1'b0;
            pos_r      <= pos_r + 1'b1;
            idx_r      <= idx_r + 1'b1;
            if (pos_r == '1) begin
              fb_r <= ks_step;  // cipher block becomes next feedback
            end
            // a waiting result keeps its data; the new one waits in plain_r
            if (step_last && out_free) begin
              out_data_r  <= is_blk_r ? {8'h00, plain_step[63:0], plain_step[127:64]}
                                      : {p_byte, 128'h0};
            end
          end
        end
        ST_KEY: begin
          rnd_r <= '0;
        end
        ST_RUN: begin
          st_r  <= rnd_out;
          rnd_r <= rnd_r + 4'd1;
          if (rnd_last) begin
            ks_r       <= rnd_out;
            refilled_r <= 1'b1;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_data_r <= is_blk_r ? {8'h00, plain_r[63:0], plain_r[127:64]}
                                   : {plain_r[7:0], 128'h0};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_BYTE || $past(state_r) == ST_HOLD))
    else $error("result raised outside byte step or hold");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rnd_r <= nr))
    else $error("round counter past round count");
  a_iv_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == cfb_pkg::OP_LOAD_IV) |=> (pos_r == '0 && !refilled_r))
    else $error("IV load did not clear position");
  a_refill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && rnd_last) |=> (state_r == ST_BYTE && refilled_r))
    else $error("keystream refill did not complete");
`endif

endmodule

`default_nettype wire

/* src/cfb_ram.sv */
// ----------------------------------------------------------------------------
// cfb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/cfb_round.sv */
// ----------------------------------------------------------------------------
// cfb_round
// One AES encryption round: whitening, middle round or final round.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_round (
  input  wire logic [cfb_pkg::BLK_W-1:0] st_i,
  input  wire logic [cfb_pkg::BLK_W-1:0] rk_i,
  input  wire logic                      first_i,
  input  wire logic                      last_i,
  output logic      [cfb_pkg::BLK_W-1:0] st_o
);

  logic [7:0] s  [16];
  logic [7:0] t  [16];
  logic [7:0] m  [16];
  logic [7:0] r  [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st_i[8*i +: 8];
    end
    // sub bytes + shift rows, column-major state
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[c*4+k] = cfb_pkg::SBOX[s[((c + k) % 4) * 4 + k]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
      m[c*4]   = t[c*4]   ^ all ^ cfb_pkg::xtime(t[c*4]   ^ t[c*4+1]);
      m[c*4+1] = t[c*4+1] ^ all ^ cfb_pkg::xtime(t[c*4+1] ^ t[c*4+2]);
      m[c*4+2] = t[c*4+2] ^ all ^ cfb_pkg::xtime(t[c*4+2] ^ t[c*4+3]);
      m[c*4+3] = t[c*4+3] ^ all ^ cfb_pkg::xtime(t[c*4+3] ^ t[c*4]);
    end
    for (int i = 0; i < 16; i++) begin
      if (first_i) begin
        r[i] = s[i];
      end else if (last_i) begin
        r[i] = t[i];
      end else begin
        r[i] = m[i];
      end
      st_o[8*i +: 8] = r[i] ^ rk_i[8*i +: 8];
    end
  end

endmodule

`default_nettype wire
